// ===== src/sra_pkg.sv =====
package sra_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  // Field widths
  localparam int POS_W    = 48;
  localparam int SAMPLE_W = 32;
  localparam int LIMIT_W  = 31;
  localparam int FREE_W   = 13;

  // Float bit layout
  localparam int EXP_LSB = 23;
  localparam int EXP_W   = 8;
  localparam logic [EXP_W-1:0]   EXP_ALL_ONES = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 31'h3F80_0000;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QA_W    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_END  = 2'd1,
    ACT_PULL = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef struct packed {
    act_t                act;
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== src/sra_front.sv =====
module sra_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [31:0]                   in_sample,
  input  logic [47:0]                   in_position,
  input  logic                          cfg_valid,
  input  logic [sra_pkg::LIMIT_W-1:0]   cfg_clamp_limit,
  output logic                          push,
  output sra_pkg::item_t                item
);
  import sra_pkg::*;

  logic [LIMIT_W-1:0]  limit_r;
  logic [LIMIT_W-1:0]  mag;
  logic [SAMPLE_W-1:0] scrubbed;

  // Hold the clamp limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_clamp_limit;
    end
  end

  // Scrub the sample: non-finite to zero, clamp magnitude keeping sign
  always_comb begin
    mag = in_sample[LIMIT_W-1:0];
    if (in_sample[EXP_LSB +: EXP_W] == EXP_ALL_ONES) begin
      scrubbed = '0;
    end else if (mag > limit_r) begin
      scrubbed = {in_sample[SAMPLE_W-1], limit_r};
    end else begin
      scrubbed = in_sample;
    end
  end

  // Classify and hand the item to the queue
  assign push        = start && !busy;
  assign item.act    = act_t'(in_action);
  assign item.sample = scrubbed;
  assign item.pos    = in_position;

endmodule

// ===== src/sra_queue.sv =====
module sra_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sra_pkg::item_t    push_item,
  input  logic              pop,
  output sra_pkg::item_t    head,
  output sra_pkg::q_stat_t  stat
);
  import sra_pkg::*;

  item_t           slot_r [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r;
  logic [QA_W-1:0] rd_ptr_r;
  logic [QA_W:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (QA_W+1)'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = slot_r[rd_ptr_r];

  // Store the item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
    end
  end

endmodule

// ===== src/sra_back.sv =====
module sra_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  sra_pkg::item_t                q_head,
  output logic                          pop,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic                          out_read_valid,
  output logic [31:0]                   out_read_sample,
  output logic                          out_ended,
  output logic [sra_pkg::FREE_W-1:0]    out_free_space
);
  import sra_pkg::*;

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;

  logic [POS_W-1:0] wr_cur_r, wr_cur_nxt;
  logic [POS_W-1:0] rd_cur_r, rd_cur_nxt;
  logic [POS_W-1:0] end_pos_r, end_pos_nxt;
  logic             end_marked_r, end_marked_nxt;
  logic             res_vld_r;
  logic             acc_r, acc_nxt;
  logic             rv_r, rv_nxt;
  logic [POS_W-1:0] pos_r;

  logic [POS_W-1:0] used;
  logic             space_ok;
  logic [CNT_W-1:0] free_full;
  logic             mem_we;

  // Free space from the current cursors; also the status of the last result
  assign used      = wr_cur_r - rd_cur_r;
  assign space_ok  = !end_marked_r && (used < POS_W'(RING_DEPTH));
  assign free_full = space_ok ? (CNT_W'(RING_DEPTH) - used[CNT_W-1:0]) : '0;

  assign pop = q_valid;

  // Carry out the head item
  always_comb begin
    wr_cur_nxt     = wr_cur_r;
    rd_cur_nxt     = rd_cur_r;
    end_pos_nxt    = end_pos_r;
    end_marked_nxt = end_marked_r;
    acc_nxt        = 1'b0;
    rv_nxt         = 1'b0;
    mem_we         = 1'b0;
    if (q_valid) begin
      unique case (q_head.act)
        ACT_PUSH: begin
          if (space_ok) begin
            mem_we     = 1'b1;
            wr_cur_nxt = wr_cur_r + 1'b1;
            acc_nxt    = 1'b1;
          end
        end
        ACT_END: begin
          if (!end_marked_r) begin
            end_marked_nxt = 1'b1;
            end_pos_nxt    = wr_cur_r;
          end
        end
        ACT_PULL: begin
          if (q_head.pos < wr_cur_r) begin
            rv_nxt     = 1'b1;
            rd_cur_nxt = q_head.pos + 1'b1;
          end
        end
        ACT_NONE: begin
        end
      endcase
    end
  end

  // Sample memory: a stored push writes; the word at the head's position is always read and registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_cur_r[ADDR_W-1:0]] <= q_head.sample;
    end
    mem_q_r <= mem[q_head.pos[ADDR_W-1:0]];
  end

  // Hold cursors, end mark and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cur_r     <= '0;
      rd_cur_r     <= '0;
      end_pos_r    <= '0;
      end_marked_r <= 1'b0;
      res_vld_r    <= 1'b0;
      acc_r        <= 1'b0;
      rv_r         <= 1'b0;
    end else begin
      wr_cur_r     <= wr_cur_nxt;
      rd_cur_r     <= rd_cur_nxt;
      end_pos_r    <= end_pos_nxt;
      end_marked_r <= end_marked_nxt;
      res_vld_r    <= q_valid;
      acc_r        <= acc_nxt;
      rv_r         <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid) begin
      pos_r <= q_head.pos;
    end
  end

  // Drive the result
  assign out_strobe      = res_vld_r;
  assign out_accepted    = acc_r;
  assign out_read_valid  = rv_r;
  assign out_read_sample = rv_r ? mem_q_r : '0;
  assign out_ended       = end_marked_r && (pos_r >= end_pos_r);
  assign out_free_space  = FREE_W'(free_full);

  // A result never both stores and reads
  assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> !(acc_r && rv_r))
    else $error("push and pull reported together");

  // The write cursor only steps by one
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (wr_cur_r != $past(wr_cur_r)) |-> wr_cur_r == $past(wr_cur_r) + 1'b1)
    else $error("write cursor jumped");

  // A stored push moved the write cursor
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && res_vld_r && acc_r |-> wr_cur_r == $past(wr_cur_r) + 1'b1)
    else $error("accepted push without cursor advance");

  // Once marked, the end stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(end_marked_r) |-> end_marked_r && $stable(end_pos_r))
    else $error("end position changed after marking");

endmodule

// ===== src/sample_ring_with_end_marker.sv =====
// Channel | Handshake              | Payload
// --------+------------------------+---------------------------------------------
// input   | start, busy            | in_action, in_sample, in_position
// result  | out_strobe (one cycle) | out_accepted, out_read_valid, out_read_sample,
//         |                        | out_ended, out_free_space
// config  | cfg_valid, cfg_ready   | cfg_clamp_limit
//
// One item per cycle sustained; a result strobes once its item has passed the queue slot
// and the back's result registers, which also hold the sample memory's registered read.
// The back takes the queue head every cycle, so the two-entry queue never fills
// and busy stays low.
// rst_n is synchronous; cursors and end mark clear, clamp limit returns to 1.0.
// The receiver cannot stall: each result is valid for exactly one cycle.
module sample_ring_with_end_marker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [31:0]                   in_sample,
  input  logic [47:0]                   in_position,
  output logic                          out_strobe,
  output logic                          out_accepted,
  output logic                          out_read_valid,
  output logic [31:0]                   out_read_sample,
  output logic                          out_ended,
  output logic [sra_pkg::FREE_W-1:0]    out_free_space,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sra_pkg::LIMIT_W-1:0]   cfg_clamp_limit
);
  import sra_pkg::*;

  logic    push;
  item_t   item;
  item_t   head;
  q_stat_t q_stat;
  logic    pop;

  assign busy      = q_stat.full;
  assign cfg_ready = 1'b1;

  sra_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_sample       (in_sample),
    .in_position     (in_position),
    .cfg_valid       (cfg_valid),
    .cfg_clamp_limit (cfg_clamp_limit),
    .push            (push),
    .item            (item)
  );

  sra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  sra_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_stat.valid),
    .q_head          (head),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_accepted    (out_accepted),
    .out_read_valid  (out_read_valid),
    .out_read_sample (out_read_sample),
    .out_ended       (out_ended),
    .out_free_space  (out_free_space)
  );

endmodule
